// File: rtl/core/euler_rotation_matrix_assert.svh
// Assertion macros for the rotation block.
`ifndef EULER_ROTATION_MATRIX_ASSERT_SVH
`define EULER_ROTATION_MATRIX_ASSERT_SVH

// A condition implies a consequence on the next edge.
`define ERM_ASSERT_NEXT(lbl, clk_s, rst_n, cond, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");

// A condition implies a consequence on the same edge.
`define ERM_ASSERT_NOW(lbl, clk_s, rst_n, cond, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/core/erm_pkg.sv
package erm_pkg;
	localparam int TrigStagesDef  = 16;
	localparam int OutFracBitsDef = 14;
	localparam int AngleW         = 17;
	localparam int OutW           = 16;
	localparam int WorkFrac       = 30;
	localparam int WorkW          = 33;
	localparam int ZW             = 24;
	localparam int FullTurn       = 46080;
	localparam int QuarterTurn    = 11520;
	localparam logic signed [WorkW-1:0] GainInit = 33'sd652032874;

	typedef logic signed [WorkW-1:0] work_t;

	function automatic logic signed [ZW-1:0] atan_deg16(input int i);
		logic signed [ZW-1:0] r;
		case (i)
			0: r = 24'sd2949120;   1: r = 24'sd1740967;  2: r = 24'sd919879;
			3: r = 24'sd466945;    4: r = 24'sd234379;   5: r = 24'sd117304;
			6: r = 24'sd58666;     7: r = 24'sd29335;    8: r = 24'sd14668;
			9: r = 24'sd7334;     10: r = 24'sd3667;    11: r = 24'sd1833;
			12: r = 24'sd917;     13: r = 24'sd458;     14: r = 24'sd229;
			15: r = 24'sd115;     16: r = 24'sd57;      17: r = 24'sd29;
			18: r = 24'sd14;      19: r = 24'sd7;       20: r = 24'sd4;
			21: r = 24'sd2;       22: r = 24'sd1;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Q30 product, rounded half up.
	function automatic work_t mulq(input work_t a, input work_t b);
		logic signed [2*WorkW-1:0] p;
		p = a * b + (66'sd1 <<< (WorkFrac - 1));
		return work_t'(p >>> WorkFrac);
	endfunction
endpackage

// File: rtl/core/erm_sincos.sv
module erm_sincos #(
	parameter int TRIG_STAGES = erm_pkg::TrigStagesDef
) (
	input  logic                              clk,
	input  logic                              en,
	input  logic signed [erm_pkg::AngleW-1:0] angle,
	output erm_pkg::work_t                    cos_v,
	output erm_pkg::work_t                    sin_v
);
	import erm_pkg::*;

	// Stage 0: wrap and fold.
	logic [1:0]           q_s1;
	logic signed [ZW-1:0] z_s1;
	logic signed [18:0]   a_wr;
	logic [15:0]          a_m;
	logic [1:0]           q_c;

	always_comb begin
		a_wr = 19'(angle);
		if (a_wr >= 19'sd46080) a_wr = a_wr - 19'sd46080;
		if (a_wr < 0) a_wr = a_wr + 19'sd46080;
		if (a_wr < 0) a_wr = a_wr + 19'sd46080;
		a_m = 16'(a_wr);
		q_c = 2'd0;
		if (a_m >= 16'(3*QuarterTurn)) begin
			q_c = 2'd3; a_m = a_m - 16'(3*QuarterTurn);
		end else if (a_m >= 16'(2*QuarterTurn)) begin
			q_c = 2'd2; a_m = a_m - 16'(2*QuarterTurn);
		end else if (a_m >= 16'(QuarterTurn)) begin
			q_c = 2'd1; a_m = a_m - 16'(QuarterTurn);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1 <= q_c;
			z_s1 <= ZW'({a_m, 9'd0});
		end
	end

	work_t                x_p [TRIG_STAGES+1];
	work_t                y_p [TRIG_STAGES+1];
	logic signed [ZW-1:0] z_p [TRIG_STAGES+1];
	logic [1:0]           q_p [TRIG_STAGES+1];

	assign x_p[0] = GainInit;
	assign y_p[0] = '0;
	assign z_p[0] = z_s1;
	assign q_p[0] = q_s1;

	// One CORDIC stage per register.
	for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_stage
		work_t                x_n, y_n;
		logic signed [ZW-1:0] z_n;
		always_comb begin
			if (z_p[i] >= 0) begin
				x_n = x_p[i] - (y_p[i] >>> i);
				y_n = y_p[i] + (x_p[i] >>> i);
				z_n = z_p[i] - atan_deg16(i);
			end else begin
				x_n = x_p[i] + (y_p[i] >>> i);
				y_n = y_p[i] - (x_p[i] >>> i);
				z_n = z_p[i] + atan_deg16(i);
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				x_p[i+1] <= x_n;
				y_p[i+1] <= y_n;
				z_p[i+1] <= z_n;
				q_p[i+1] <= q_p[i];
			end
		end
	end

	work_t xf, yf;
	assign xf = x_p[TRIG_STAGES];
	assign yf = y_p[TRIG_STAGES];

	always_comb begin
		case (q_p[TRIG_STAGES])
			2'd0: begin cos_v = xf;  sin_v = yf;  end
			2'd1: begin cos_v = -yf; sin_v = xf;  end
			2'd2: begin cos_v = -xf; sin_v = -yf; end
			default: begin cos_v = yf; sin_v = -xf; end
		endcase
	end
endmodule

// File: rtl/core/euler_rotation_matrix.sv
// Channel  | Signals                          | Transfer
// input    | start, busy, angle_x/y/z         | start high while busy low
// result   | done, m00..m22                   | done high for one cycle
//
// One angle triple enters per cycle; busy stays low.
// Each triple passes the wrap register, the CORDIC stage registers, the
// triple-product chain and the output rounding register.
// Reset clears the valid bits only; payload registers are not reset.
// The receiver cannot stall, so the pipe always advances.
module euler_rotation_matrix #(
	parameter int TRIG_STAGES   = erm_pkg::TrigStagesDef,
	parameter int OUT_FRAC_BITS = erm_pkg::OutFracBitsDef
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [erm_pkg::AngleW-1:0] angle_x,
	input  logic signed [erm_pkg::AngleW-1:0] angle_y,
	input  logic signed [erm_pkg::AngleW-1:0] angle_z,
	output logic                              done,
	output logic signed [erm_pkg::OutW-1:0]   m00,
	output logic signed [erm_pkg::OutW-1:0]   m01,
	output logic signed [erm_pkg::OutW-1:0]   m02,
	output logic signed [erm_pkg::OutW-1:0]   m10,
	output logic signed [erm_pkg::OutW-1:0]   m11,
	output logic signed [erm_pkg::OutW-1:0]   m12,
	output logic signed [erm_pkg::OutW-1:0]   m20,
	output logic signed [erm_pkg::OutW-1:0]   m21,
	output logic signed [erm_pkg::OutW-1:0]   m22
);
	import erm_pkg::*;
	`include "euler_rotation_matrix_assert.svh"

	localparam int Lat = TRIG_STAGES + 5;
	localparam int Sh  = WorkFrac - OUT_FRAC_BITS;

	// Never stall the input side.
	assign busy = 1'b0;

	logic en;
	assign en = 1'b1;

	// Valid bits ride along with the data.
	logic [Lat-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[Lat-2:0], start & ~busy};
	end
	assign done = vld_q[Lat-1];

	work_t cx, sx, cy, sy, cz, sz;
	erm_sincos #(.TRIG_STAGES(TRIG_STAGES)) u_sx (.clk, .en,
		.angle(angle_x), .cos_v(cx), .sin_v(sx));
	erm_sincos #(.TRIG_STAGES(TRIG_STAGES)) u_sy (.clk, .en,
		.angle(angle_y), .cos_v(cy), .sin_v(sy));
	erm_sincos #(.TRIG_STAGES(TRIG_STAGES)) u_sz (.clk, .en,
		.angle(angle_z), .cos_v(cz), .sin_v(sz));

	// Stage A: first products; hold trig values for the second round.
	work_t czcy_s1, szcx_s1, czsy_s1, szcy_s1, szsy_s1, czcx_s1, czsx_s1, szsx_s1;
	work_t cycx_s1, cysx_s1, sy_s1, cx_s1, sx_s1;
	always_ff @(posedge clk) begin
		czcy_s1 <= mulq(cz, cy);  szcx_s1 <= mulq(sz, cx);
		czsy_s1 <= mulq(cz, sy);  szcy_s1 <= mulq(sz, cy);
		szsy_s1 <= mulq(sz, sy);  czcx_s1 <= mulq(cz, cx);
		czsx_s1 <= mulq(cz, sx);  szsx_s1 <= mulq(sz, sx);
		cycx_s1 <= mulq(cy, cx);  cysx_s1 <= mulq(cy, sx);
		sy_s1 <= sy; cx_s1 <= cx; sx_s1 <= sx;
	end

	// Stage B: triple products.
	work_t t01_s2, t02_s2, t11_s2, t12_s2;
	work_t czcy_s2, szcx_s2, szcy_s2, czcx_s2, czsx_s2, szsx_s2, cycx_s2, cysx_s2;
	work_t sy_s2;
	always_ff @(posedge clk) begin
		t01_s2 <= mulq(czsy_s1, sx_s1);
		t02_s2 <= mulq(czsy_s1, cx_s1);
		t11_s2 <= mulq(szsy_s1, sx_s1);
		t12_s2 <= mulq(szsy_s1, cx_s1);
		czcy_s2 <= czcy_s1; szcx_s2 <= szcx_s1; szcy_s2 <= szcy_s1;
		czcx_s2 <= czcx_s1; czsx_s2 <= czsx_s1; szsx_s2 <= szsx_s1;
		cycx_s2 <= cycx_s1; cysx_s2 <= cysx_s1; sy_s2 <= sy_s1;
	end

	// Stage C: sums.
	work_t e_s3 [9];
	always_ff @(posedge clk) begin
		e_s3[0] <= czcy_s2;
		e_s3[1] <= szcx_s2 - t01_s2;
		e_s3[2] <= t02_s2 + szsx_s2;
		e_s3[3] <= -szcy_s2;
		e_s3[4] <= t11_s2 + czcx_s2;
		e_s3[5] <= czsx_s2 - t12_s2;
		e_s3[6] <= -sy_s2;
		e_s3[7] <= -cysx_s2;
		e_s3[8] <= cycx_s2;
	end

	// Stage D: round half up and saturate.
	function automatic logic signed [OutW-1:0] to_out(input work_t v);
		logic signed [WorkW:0] r;
		logic signed [WorkW:0] lim;
		lim = (WorkW+1)'(1) <<< OUT_FRAC_BITS;
		r = (WorkW+1)'(v);
		if (Sh > 0) r = (r + ((WorkW+1)'(1) <<< (Sh - 1))) >>> Sh;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r[OutW-1:0];
	endfunction

	logic signed [OutW-1:0] o_s4 [9];
	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) o_s4[k] <= to_out(e_s3[k]);
	end

	assign m00 = o_s4[0]; assign m01 = o_s4[1]; assign m02 = o_s4[2];
	assign m10 = o_s4[3]; assign m11 = o_s4[4]; assign m12 = o_s4[5];
	assign m20 = o_s4[6]; assign m21 = o_s4[7]; assign m22 = o_s4[8];

	`ERM_ASSERT_NOW(a_never_busy, clk, arst_n, 1'b1, !busy)
	`ERM_ASSERT_NEXT(a_accept_travels, clk, arst_n, start, vld_q[0])
	`ERM_ASSERT_NEXT(a_idle_gap, clk, arst_n, !vld_q[Lat-2], !done)
endmodule

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;
	import erm_pkg::*;

	localparam int NStages   = TrigStagesDef;
	localparam int NFrac     = OutFracBitsDef;
	localparam int Latency   = NStages + 5;
	localparam int DogLimit  = 20000;
	localparam int NRandom   = 1900;
	localparam int NRows     = 20;

	typedef logic signed [OutW-1:0] entry_t;
	typedef struct packed {
		entry_t e00, e01, e02, e10, e11, e12, e20, e21, e22;
	} matrix_t;
	typedef logic signed [AngleW-1:0] angle_t;
	typedef struct {
		angle_t ax, ay, az;
		bit     known;
		matrix_t m;
	} row_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   start = 1'b0;
	angle_t angle_x = '0, angle_y = '0, angle_z = '0;
	logic   busy, done;
	entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

	matrix_t expected_mats[$];
	int      mismatches = 0;
	int      dog = 0;
	int      n_sent = 0;
	int      n_checked = 0;
	int      send_idle_pct = 7;
	row_t    rows[NRows];

	euler_rotation_matrix u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.angle_x(angle_x), .angle_y(angle_y), .angle_z(angle_z), .done(done),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22)
	);

	always #4 clk = ~clk;

	// Floor shift right on wide signed values.
	function automatic longint floor_shr(input longint v, input int sh);
		return v >>> sh;
	endfunction

	// Q30 product with half-up rounding.
	function automatic longint q30_mul(input longint a, input longint b);
		return floor_shr(a * b + (64'sd1 <<< (WorkFrac - 1)), WorkFrac);
	endfunction

	// Round Q30 to the output fraction and clamp to plus or minus one.
	function automatic entry_t q30_to_entry(input longint v);
		longint r, lim;
		int sh;
		sh  = WorkFrac - NFrac;
		lim = 64'sd1 <<< NFrac;
		r   = floor_shr(v + (64'sd1 <<< (sh - 1)), sh);
		if (r > lim) begin
			r = lim;
		end
		if (r < -lim) begin
			r = -lim;
		end
		return entry_t'(r);
	endfunction

	// Fold the angle into a quadrant and run the CORDIC in rotation mode.
	task automatic cordic_sin_cos(input angle_t ang, output longint c, output longint s);
		longint a, q, z, x, y, dx, dy;
		longint tbl[24];
		tbl = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
			14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
		a = longint'(ang) % FullTurn;
		if (a < 0) begin
			a += FullTurn;
		end
		q = a / QuarterTurn;
		z = (a % QuarterTurn) * 512;
		x = 652032874;
		y = 0;
		for (int i = 0; i < NStages; i++) begin
			dx = floor_shr(y, i);
			dy = floor_shr(x, i);
			if (z >= 0) begin
				x -= dx; y += dy; z -= tbl[i];
			end else begin
				x += dx; y -= dy; z += tbl[i];
			end
		end
		case (q)
			0: begin c = x;  s = y;  end
			1: begin c = -y; s = x;  end
			2: begin c = -x; s = -y; end
			default: begin c = y; s = -x; end
		endcase
	endtask

	// Build Rz * Ry * Rx from the three angles.
	task automatic rotation_of(input angle_t ax, input angle_t ay, input angle_t az,
			output matrix_t m);
		longint cx, sx, cy, sy, cz, sz, czsy, szsy;
		cordic_sin_cos(ax, cx, sx);
		cordic_sin_cos(ay, cy, sy);
		cordic_sin_cos(az, cz, sz);
		czsy  = q30_mul(cz, sy);
		szsy  = q30_mul(sz, sy);
		m.e00 = q30_to_entry(q30_mul(cz, cy));
		m.e01 = q30_to_entry(q30_mul(sz, cx) - q30_mul(czsy, sx));
		m.e02 = q30_to_entry(q30_mul(czsy, cx) + q30_mul(sz, sx));
		m.e10 = q30_to_entry(-q30_mul(sz, cy));
		m.e11 = q30_to_entry(q30_mul(szsy, sx) + q30_mul(cz, cx));
		m.e12 = q30_to_entry(q30_mul(cz, sx) - q30_mul(szsy, cx));
		m.e20 = q30_to_entry(-sy);
		m.e21 = q30_to_entry(-q30_mul(cy, sx));
		m.e22 = q30_to_entry(q30_mul(cy, cx));
	endtask

	function automatic angle_t rand_angle();
		// Mostly in range, sometimes any 17-bit pattern or a multiple of a quarter turn.
		case ($urandom_range(0, 9))
			0: return angle_t'($urandom);
			1: return angle_t'(($urandom_range(0, 8) - 4) * QuarterTurn);
			default: return angle_t'(int'($urandom_range(0, 2 * FullTurn)) - FullTurn);
		endcase
	endfunction

	// Push one transaction and its predicted matrix; hold start across back-to-back items.
	task automatic send_item(input angle_t ax, input angle_t ay, input angle_t az,
			input bit known, input matrix_t typed_m);
		matrix_t m;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		rotation_of(ax, ay, az, m);
		if (known && m !== typed_m) begin
			$display("table row disagrees with predictor: %h vs %h", typed_m, m);
			mismatches++;
		end
		start   <= 1'b1;
		angle_x <= ax;
		angle_y <= ay;
		angle_z <= az;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		expected_mats.push_back(m);
		n_sent++;
	endtask

	// Compare each strobed result with the oldest prediction.
	always @(posedge clk) begin
		matrix_t got, want;
		if (done) begin
			got = {m00, m01, m02, m10, m11, m12, m20, m21, m22};
			if (expected_mats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result %h", got);
				end
			end else begin
				want = expected_mats.pop_front();
				n_checked++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: expected %h actual %h", want, got);
					end
				end
			end
		end
	end

	// Watchdog: count cycles where nothing is accepted on either side.
	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			dog <= 0;
		end else begin
			dog <= dog + 1;
		end
		if (dog >= DogLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	localparam matrix_t Ident = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384};

	initial begin
		// Directed table: identity rows are typed in, the rest are predicted.
		rows[0]  = '{0, 0, 0, 1, Ident};
		rows[1]  = '{FullTurn, 0, 0, 1, Ident};
		rows[2]  = '{-FullTurn, FullTurn, -FullTurn, 1, Ident};
		rows[3]  = '{65535, 0, 0, 0, Ident};
		rows[4]  = '{-65536, 0, 0, 0, Ident};
		rows[5]  = '{0, 65535, -65536, 0, Ident};
		rows[6]  = '{QuarterTurn, 0, 0, 0, Ident};
		rows[7]  = '{0, QuarterTurn, 0, 0, Ident};
		rows[8]  = '{0, 0, QuarterTurn, 0, Ident};
		rows[9]  = '{2 * QuarterTurn, 2 * QuarterTurn, 2 * QuarterTurn, 0, Ident};
		rows[10] = '{3 * QuarterTurn, -QuarterTurn, 3 * QuarterTurn, 0, Ident};
		rows[11] = '{1, -1, 1, 0, Ident};
		rows[12] = '{QuarterTurn - 1, QuarterTurn + 1, -QuarterTurn - 1, 0, Ident};
		rows[13] = '{5760, 5760, 5760, 0, Ident};
		rows[14] = '{-5760, 3840, 7680, 0, Ident};
		rows[15] = '{FullTurn - 1, -FullTurn + 1, FullTurn + 1, 0, Ident};
		rows[16] = '{43690, -21845, 12345, 0, Ident};
		rows[17] = '{-43690, 21845, -12345, 0, Ident};
		rows[18] = '{0, 0, 5760, 0, Ident};
		rows[19] = '{0, -5760, 0, 0, Ident};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < NRows; i++) begin
			send_item(rows[i].ax, rows[i].ay, rows[i].az, rows[i].known, rows[i].m);
		end
		// Random phases: sender idle at 7 percent, then 50, then none.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 50 : 0;
			for (int k = 0; k < NRandom / 3; k++) begin
				send_item(rand_angle(), rand_angle(), rand_angle(), 1'b0, Ident);
				if (ph == 0 && k == 100) begin
					// Pause until every predicted matrix has been drained.
					start <= 1'b0;
					while (expected_mats.size() != 0) begin
						@(posedge clk);
					end
				end
			end
		end
		start <= 1'b0;
		while (expected_mats.size() != 0) begin
			@(posedge clk);
		end
		repeat (Latency + 5) @(posedge clk);
		$display("Sent %0d angle triples (directed extremes, quadrant edges, wrap cases,", n_sent);
		$display("random angles over full 17-bit range); %0d matrices checked.", n_checked);
		if (mismatches == 0 && expected_mats.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
